### rtl/core/cpqm_pkg.sv
package cpqm_pkg;

  localparam int GAIN_W  = 20;
  localparam int RX_W    = 12;
  localparam int ERR_W   = 20;
  localparam int INTEG_W = 26;
  localparam int PID_W   = 18;
  localparam int TGT_W   = 18;
  localparam int MUL_W   = 30;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = 64;
  localparam int MOTOR_W = 11;
  localparam int NUM_PID = 5;
  localparam int CFG_IDX_W = 3;

  // floor(u / 5) = (u * DIV5_M) >> 22 for u below 2^20.
  localparam logic [MUL_W-1:0] DIV5_M = 30'd838861;
  // floor(u / 125) = (u * DIV125_M) >> 35 for u below 2^28.
  localparam logic [MUL_W-1:0] DIV125_M = 30'd274877907;
  // The integral step divides e * 128 + 125 * N by 125 so the dividend is never negative.
  localparam logic [MUL_W-1:0] DIV125_BIAS   = 30'd67108875;
  localparam logic signed [22:0] DIV125_BIAS_N = 23'sd536871;

  localparam logic signed [18:0] TGT_RP_OFS = 19'sd38400;
  localparam logic signed [18:0] TGT_Y_OFS  = 19'sd57600;

  localparam logic signed [26:0] INTEG_LIM = 27'sd26214400;
  localparam logic signed [39:0] OUT_LIM   = 40'sd102400;

  localparam logic [RX_W-1:0] THR_MIN = 12'd1000;
  localparam logic [RX_W-1:0] THR_MAX = 12'd1800;
  localparam logic [10:0]     MOTOR_BASE = 11'd1100;
  localparam logic [MOTOR_W-1:0] MOTOR_OFF = 11'd1000;
  localparam logic signed [21:0] MIX_LO = 22'sd281600;
  localparam logic signed [21:0] MIX_HI = 22'sd512000;

  localparam logic [GAIN_W-1:0] ANGLE_KP_RST = 20'd131072;
  localparam logic [GAIN_W-1:0] ANGLE_KI_RST = 20'd32768;
  localparam logic [GAIN_W-1:0] ANGLE_KD_RST = 20'd459;
  localparam logic [GAIN_W-1:0] RATE_KP_RST  = 20'd40960;
  localparam logic [GAIN_W-1:0] RATE_KI_RST  = 20'd137626;
  localparam logic [GAIN_W-1:0] RATE_KD_RST  = 20'd577;
  localparam logic [GAIN_W-1:0] YAW_KP_RST   = 20'd262144;
  localparam logic [GAIN_W-1:0] YAW_KI_RST   = 20'd196608;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_KP = 3'd0,
    REG_ANGLE_KI = 3'd1,
    REG_ANGLE_KD = 3'd2,
    REG_RATE_KP  = 3'd3,
    REG_RATE_KI  = 3'd4,
    REG_RATE_KD  = 3'd5,
    REG_YAW_KP   = 3'd6,
    REG_YAW_KI   = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    PID_ANG_ROLL   = 3'd0,
    PID_ANG_PITCH  = 3'd1,
    PID_RATE_ROLL  = 3'd2,
    PID_RATE_PITCH = 3'd3,
    PID_RATE_YAW   = 3'd4
  } pid_idx_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_TGT_R,
    MUL_TGT_P,
    MUL_TGT_Y,
    MUL_DIV,
    MUL_KP,
    MUL_KI,
    MUL_KD
  } mul_sel_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_TGT_R,
    WB_TGT_P,
    WB_TGT_Y,
    WB_INTEG,
    WB_ACC_P1,
    WB_ACC_P2,
    WB_ACC_P3,
    WB_OUT
  } wb_sel_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    wb_sel_t  wb_sel;
    pid_idx_t pid;
    logic     load_out;
  } cpqm_cmd_t;

  // Fields from the lowest bit up: rx_roll first.
  typedef struct packed {
    logic [5:0]        pad;
    logic signed [17:0] yaw_rate;
    logic signed [17:0] pitch_rate;
    logic signed [17:0] roll_rate;
    logic signed [13:0] pitch_angle;
    logic signed [13:0] roll_angle;
    logic [RX_W-1:0]   rx_yaw;
    logic [RX_W-1:0]   rx_throttle;
    logic [RX_W-1:0]   rx_pitch;
    logic [RX_W-1:0]   rx_roll;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         pad;
    logic [MOTOR_W-1:0] motor_front_left;
    logic [MOTOR_W-1:0] motor_rear_left;
    logic [MOTOR_W-1:0] motor_rear_right;
    logic [MOTOR_W-1:0] motor_front_right;
  } out_word_t;

endpackage

### rtl/core/cpqm_ctrl.sv
module cpqm_ctrl
  import cpqm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output cpqm_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TGT,
    ST_PID,
    ST_MIX
  } state_t;

  localparam logic [2:0] TGT_LAST = 3'd3;
  localparam logic [2:0] PID_STEP_LAST = 3'd5;

  state_t     state;
  logic [2:0] sub;
  pid_idx_t   pid;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd.mul_sel  = MUL_NONE;
    cmd.wb_sel   = WB_NONE;
    cmd.pid      = pid;
    cmd.load_out = 1'b0;
    case (state)
      ST_TGT: begin
        case (sub)
          3'd0: cmd.mul_sel = MUL_TGT_Y;
          3'd1: begin
            cmd.mul_sel = MUL_TGT_P;
            cmd.wb_sel  = WB_TGT_Y;
          end
          3'd2: begin
            cmd.mul_sel = MUL_TGT_R;
            cmd.wb_sel  = WB_TGT_P;
          end
          default: cmd.wb_sel = WB_TGT_R;
        endcase
      end
      ST_PID: begin
        case (sub)
          3'd0: cmd.mul_sel = MUL_DIV;
          3'd1: begin
            cmd.mul_sel = MUL_KP;
            cmd.wb_sel  = WB_INTEG;
          end
          3'd2: begin
            cmd.mul_sel = MUL_KI;
            cmd.wb_sel  = WB_ACC_P1;
          end
          3'd3: begin
            cmd.mul_sel = MUL_KD;
            cmd.wb_sel  = WB_ACC_P2;
          end
          3'd4: cmd.wb_sel = WB_ACC_P3;
          default: cmd.wb_sel = WB_OUT;
        endcase
      end
      ST_MIX: cmd.load_out = !out_valid || out_ready;
      default: cmd.load_out = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sub       <= 3'd0;
      pid       <= PID_ANG_ROLL;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_TGT;
            sub   <= 3'd0;
          end
        end
        ST_TGT: begin
          if (sub == TGT_LAST) begin
            state <= ST_PID;
            sub   <= 3'd0;
            pid   <= PID_ANG_ROLL;
          end else begin
            sub <= sub + 3'd1;
          end
        end
        ST_PID: begin
          if (sub == PID_STEP_LAST) begin
            sub <= 3'd0;
            if (pid == PID_RATE_YAW) begin
              state <= ST_MIX;
            end else begin
              pid <= pid_idx_t'(pid + 3'd1);
            end
          end else begin
            sub <= sub + 3'd1;
          end
        end
        ST_MIX: begin
          if (cmd.load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/cpqm_datapath.sv
module cpqm_datapath
  import cpqm_pkg::*;
#(
  parameter logic [GAIN_W-1:0] YAW_KD = 20'd0
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  cpqm_cmd_t            cmd,
  input  logic                 in_load,
  input  in_word_t             in_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  output out_word_t            out_word,
  output logic                 out_armed
);

  logic [GAIN_W-1:0] angle_kp, angle_ki, angle_kd;
  logic [GAIN_W-1:0] rate_kp, rate_ki, rate_kd;
  logic [GAIN_W-1:0] yaw_kp, yaw_ki;

  in_word_t in_reg;

  logic signed [TGT_W-1:0]   tgt_r, tgt_p, tgt_y;
  logic signed [ERR_W-1:0]   err;
  logic signed [INTEG_W-1:0] integ_cur;
  logic signed [ACC_W-1:0]   acc;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PID_W-1:0]   pid_out [NUM_PID];
  logic signed [INTEG_W-1:0] integ_mem [NUM_PID];
  logic signed [ERR_W-1:0]   last_mem [NUM_PID];

  logic [GAIN_W-1:0]        kp_sel, ki_sel, kd_sel;
  logic signed [ERR_W-1:0]  err_next;
  logic signed [ERR_W:0]    diff;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic [19:0]              yaw_scaled;
  logic [MUL_W-1:0]         div_num;
  logic signed [18:0]       tgt_y_calc, tgt_rp_calc;
  logic signed [22:0]       integ_delta;
  logic signed [26:0]       integ_sum, integ_clamped;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [39:0]       acc_q8, out_clamped;

  logic                     armed;
  logic [RX_W-1:0]          thr_clamped;
  logic [9:0]               thr_ofs;
  logic [12:0]              thr_x7;
  logic [10:0]              thr_sum;
  logic signed [21:0]       base, pr, pp, py;
  logic signed [21:0]       mix [4];
  logic [MOTOR_W-1:0]       motor [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_kp <= ANGLE_KP_RST;
      angle_ki <= ANGLE_KI_RST;
      angle_kd <= ANGLE_KD_RST;
      rate_kp  <= RATE_KP_RST;
      rate_ki  <= RATE_KI_RST;
      rate_kd  <= RATE_KD_RST;
      yaw_kp   <= YAW_KP_RST;
      yaw_ki   <= YAW_KI_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ANGLE_KP: angle_kp <= cfg_data;
        REG_ANGLE_KI: angle_ki <= cfg_data;
        REG_ANGLE_KD: angle_kd <= cfg_data;
        REG_RATE_KP:  rate_kp  <= cfg_data;
        REG_RATE_KI:  rate_ki  <= cfg_data;
        REG_RATE_KD:  rate_kd  <= cfg_data;
        REG_YAW_KP:   yaw_kp   <= cfg_data;
        REG_YAW_KI:   yaw_ki   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.pid)
      PID_ANG_ROLL, PID_ANG_PITCH: begin
        kp_sel = angle_kp;
        ki_sel = angle_ki;
        kd_sel = angle_kd;
      end
      PID_RATE_ROLL, PID_RATE_PITCH: begin
        kp_sel = rate_kp;
        ki_sel = rate_ki;
        kd_sel = rate_kd;
      end
      default: begin
        kp_sel = yaw_kp;
        ki_sel = yaw_ki;
        kd_sel = YAW_KD;
      end
    endcase
  end

  always_comb begin
    case (cmd.pid)
      PID_ANG_ROLL:   err_next = ERR_W'(tgt_r) - ERR_W'(in_reg.roll_angle);
      PID_ANG_PITCH:  err_next = ERR_W'(tgt_p) - ERR_W'(in_reg.pitch_angle);
      PID_RATE_ROLL:  err_next = ERR_W'(pid_out[PID_ANG_ROLL]) - ERR_W'(in_reg.roll_rate);
      PID_RATE_PITCH: err_next = ERR_W'(pid_out[PID_ANG_PITCH]) - ERR_W'(in_reg.pitch_rate);
      default:        err_next = ERR_W'(tgt_y) - ERR_W'(in_reg.yaw_rate);
    endcase
  end

  assign diff       = (ERR_W+1)'(err) - (ERR_W+1)'(last_mem[cmd.pid]);
  assign yaw_scaled = {1'b0, in_reg.rx_yaw, 7'b0} + {2'b0, in_reg.rx_yaw, 6'b0};
  assign div_num    = MUL_W'(err_next) * MUL_W'(128) + DIV125_BIAS;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_TGT_R: begin
        mul_a = $signed({11'b0, in_reg.rx_roll, 7'b0});
        mul_b = $signed(DIV5_M);
      end
      MUL_TGT_P: begin
        mul_a = $signed({11'b0, in_reg.rx_pitch, 7'b0});
        mul_b = $signed(DIV5_M);
      end
      MUL_TGT_Y: begin
        mul_a = $signed({10'b0, yaw_scaled});
        mul_b = $signed(DIV5_M);
      end
      MUL_DIV: begin
        mul_a = $signed(div_num);
        mul_b = $signed(DIV125_M);
      end
      MUL_KP: begin
        mul_a = $signed({10'b0, kp_sel});
        mul_b = MUL_W'(err);
      end
      MUL_KI: begin
        mul_a = $signed({10'b0, ki_sel});
        mul_b = MUL_W'(integ_cur);
      end
      MUL_KD: begin
        mul_a = $signed({10'b0, kd_sel});
        mul_b = MUL_W'(diff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign tgt_rp_calc = $signed({1'b0, prod[39:22]}) - TGT_RP_OFS;
  assign tgt_y_calc  = $signed({1'b0, prod[39:22]}) - TGT_Y_OFS;

  assign integ_delta = $signed({1'b0, prod[56:35]}) - DIV125_BIAS_N;
  assign integ_sum   = 27'(integ_mem[cmd.pid]) + 27'(integ_delta);
  assign integ_clamped = (integ_sum > INTEG_LIM)  ? INTEG_LIM :
                         (integ_sum < -INTEG_LIM) ? -INTEG_LIM : integ_sum;

  assign prod_ext = ACC_W'(prod);

  // Drop the 24 extra fraction bits of the Q32 sum, rounding toward minus infinity.
  assign acc_q8 = acc[63:24];
  assign out_clamped = (acc_q8 > OUT_LIM)  ? OUT_LIM :
                       (acc_q8 < -OUT_LIM) ? -OUT_LIM : acc_q8;

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_reg <= in_word;
    end
    if (cmd.mul_sel != MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.mul_sel == MUL_DIV) begin
      err <= err_next;
    end
    case (cmd.wb_sel)
      WB_TGT_R:  tgt_r <= tgt_rp_calc[TGT_W-1:0];
      WB_TGT_P:  tgt_p <= tgt_rp_calc[TGT_W-1:0];
      WB_TGT_Y:  tgt_y <= tgt_y_calc[TGT_W-1:0];
      WB_INTEG:  integ_cur <= integ_clamped[INTEG_W-1:0];
      WB_ACC_P1: acc <= prod_ext <<< 8;
      WB_ACC_P2: acc <= acc + prod_ext;
      // 250 * 256 = 65536 - 1024 - 512
      WB_ACC_P3: acc <= acc + (prod_ext <<< 16) - (prod_ext <<< 10) - (prod_ext <<< 9);
      WB_OUT:    pid_out[cmd.pid] <= out_clamped[PID_W-1:0];
      default: ;
    endcase
  end

  // PID history: integrals and last errors, cleared by reset and on disarm.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PID; i++) begin
        integ_mem[i] <= '0;
        last_mem[i]  <= '0;
      end
    end else if (cmd.load_out && !armed) begin
      for (int i = 0; i < NUM_PID; i++) begin
        integ_mem[i] <= '0;
        last_mem[i]  <= '0;
      end
    end else begin
      if (cmd.wb_sel == WB_INTEG) begin
        integ_mem[cmd.pid] <= integ_clamped[INTEG_W-1:0];
      end
      if (cmd.mul_sel == MUL_KD) begin
        last_mem[cmd.pid] <= err;
      end
    end
  end

  assign armed = (in_reg.rx_throttle >= THR_MIN);
  assign thr_clamped = (in_reg.rx_throttle < THR_MIN) ? THR_MIN :
                       (in_reg.rx_throttle > THR_MAX) ? THR_MAX : in_reg.rx_throttle;
  assign thr_ofs = 10'(thr_clamped - THR_MIN);
  assign thr_x7  = {thr_ofs, 3'b0} - {3'b0, thr_ofs};
  assign thr_sum = MOTOR_BASE + {1'b0, thr_x7[12:3]};
  assign base    = $signed({3'b0, thr_sum, 8'b0});
  assign pr      = 22'(pid_out[PID_RATE_ROLL]);
  assign pp      = 22'(pid_out[PID_RATE_PITCH]);
  assign py      = 22'(pid_out[PID_RATE_YAW]);

  assign mix[0] = base - pr - pp - py;
  assign mix[1] = base - pr + pp + py;
  assign mix[2] = base + pr + pp - py;
  assign mix[3] = base + pr - pp + py;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (!armed) begin
        motor[i] = MOTOR_OFF;
      end else if (mix[i] < MIX_LO) begin
        motor[i] = MIX_LO[18:8];
      end else if (mix[i] > MIX_HI) begin
        motor[i] = MIX_HI[18:8];
      end else begin
        motor[i] = mix[i][18:8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word.pad               <= '0;
      out_word.motor_front_right <= motor[0];
      out_word.motor_rear_right  <= motor[1];
      out_word.motor_rear_left   <= motor[2];
      out_word.motor_front_left  <= motor[3];
      out_armed                  <= armed;
    end
  end

endmodule

### rtl/core/cascaded_pid_quad_mixer.sv
// Cascaded roll/pitch angle and roll/pitch/yaw rate PID controller with an X quad
// mixer. One word in gives one word out. A word is taken only while the block is
// idle, so the next word can be accepted only after the result is loaded into the
// output register. The single shared 30x30 multiplier steps through three
// stick-target scalings and five PID loops of six steps each, followed by the
// mixer step. The output word
// is held in its own register, so a stalled output does not block the next
// tick's computation, only its final write. Gains are to be written through the cfg
// channel only while no tick is in flight; the block itself does not enforce this.
module cascaded_pid_quad_mixer
  import cpqm_pkg::*;
#(
  parameter logic [19:0] YAW_KD = 20'd0
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // rx_roll, rx_pitch, rx_throttle, rx_yaw, roll_angle, pitch_angle,
  // roll_rate, pitch_rate, yaw_rate, zero pad
  input  logic [135:0]         s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // motor_front_right, motor_rear_right, motor_rear_left, motor_front_left, zero pad
  output logic [47:0]          m_tdata,
  // armed
  output logic                 m_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data
);

  cpqm_cmd_t cmd;
  out_word_t out_word;

  assign cfg_ready = 1'b1;
  assign m_tdata   = out_word;

  cpqm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  cpqm_datapath #(
    .YAW_KD (YAW_KD)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_load   (s_tvalid && s_tready),
    .in_word   (in_word_t'(s_tdata)),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_word  (out_word),
    .out_armed (m_tuser)
  );

endmodule

### verif/cpqm_checker.sv
module cpqm_checker
  import cpqm_pkg::*;
#(
  parameter logic [19:0] YAW_KD = 20'd0
)
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [135:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [47:0]  m_tdata,
  input  logic         m_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  output int           err_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [MOTOR_W-1:0] motor[4];
    logic               armed;
  } motor_cmd_t;

  longint gain[8];
  longint integ[NUM_PID];
  longint last_err[NUM_PID];
  motor_cmd_t motor_q[$];

  assign pending = motor_q.size();

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint pid_update(int k, longint e, longint kp, longint ki, longint kd);
    longint i_val, der, acc;
    i_val = clip(integ[k] + floor_div(e * 128, 125), -26214400, 26214400);
    integ[k] = i_val;
    der = (e - last_err[k]) * 250;
    last_err[k] = e;
    acc = kp * e * 256 + ki * i_val + kd * der * 256;
    return clip(floor_div(acc, 64'sd1 << 24), -102400, 102400);
  endfunction

  function automatic motor_cmd_t mix_tick(in_word_t w);
    motor_cmd_t c;
    longint tr, tp, ty, rr, rp, pr, pp, py, thr, base, m[4];
    tr = floor_div((longint'(w.rx_roll) - 1500) * 128, 5);
    tp = floor_div((longint'(w.rx_pitch) - 1500) * 128, 5);
    ty = floor_div((longint'(w.rx_yaw) - 1500) * 192, 5);
    rr = pid_update(PID_ANG_ROLL, tr - longint'(w.roll_angle),
                    gain[REG_ANGLE_KP], gain[REG_ANGLE_KI], gain[REG_ANGLE_KD]);
    rp = pid_update(PID_ANG_PITCH, tp - longint'(w.pitch_angle),
                    gain[REG_ANGLE_KP], gain[REG_ANGLE_KI], gain[REG_ANGLE_KD]);
    pr = pid_update(PID_RATE_ROLL, rr - longint'(w.roll_rate),
                    gain[REG_RATE_KP], gain[REG_RATE_KI], gain[REG_RATE_KD]);
    pp = pid_update(PID_RATE_PITCH, rp - longint'(w.pitch_rate),
                    gain[REG_RATE_KP], gain[REG_RATE_KI], gain[REG_RATE_KD]);
    py = pid_update(PID_RATE_YAW, ty - longint'(w.yaw_rate),
                    gain[REG_YAW_KP], gain[REG_YAW_KI], longint'(YAW_KD));
    thr = (clip(longint'(w.rx_throttle), 1000, 1800) - 1000) * 700 / 800;
    base = (1100 + thr) * 256;
    m[0] = base - pr - pp - py;
    m[1] = base - pr + pp + py;
    m[2] = base + pr + pp - py;
    m[3] = base + pr - pp + py;
    if (w.rx_throttle < THR_MIN) begin
      for (int i = 0; i < 4; i++) c.motor[i] = MOTOR_OFF;
      c.armed = 1'b0;
      for (int i = 0; i < NUM_PID; i++) begin
        integ[i] = 0;
        last_err[i] = 0;
      end
    end else begin
      for (int i = 0; i < 4; i++) c.motor[i] = MOTOR_W'(clip(m[i], 281600, 512000) >>> 8);
      c.armed = 1'b1;
    end
    return c;
  endfunction

  always @(posedge clk) begin
    motor_cmd_t exp_c;
    out_word_t ow;
    if (rst) begin
      gain[0] = ANGLE_KP_RST; gain[1] = ANGLE_KI_RST; gain[2] = ANGLE_KD_RST;
      gain[3] = RATE_KP_RST;  gain[4] = RATE_KI_RST;  gain[5] = RATE_KD_RST;
      gain[6] = YAW_KP_RST;   gain[7] = YAW_KI_RST;
      for (int i = 0; i < NUM_PID; i++) begin
        integ[i] = 0;
        last_err[i] = 0;
      end
      motor_q.delete();
      err_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) gain[cfg_index] = cfg_data;
      if (s_tvalid && s_tready) motor_q.push_back(mix_tick(in_word_t'(s_tdata)));
      if (m_tvalid && m_tready) begin
        ow = out_word_t'(m_tdata);
        if (motor_q.size() == 0) begin
          $display("%t: unexpected word, actual %h armed %b", $realtime, m_tdata, m_tuser);
          err_count <= err_count + 1;
        end else begin
          exp_c = motor_q.pop_front();
          if (ow.motor_front_right !== exp_c.motor[0] || ow.motor_rear_right !== exp_c.motor[1] ||
              ow.motor_rear_left !== exp_c.motor[2] || ow.motor_front_left !== exp_c.motor[3] ||
              ow.pad !== 4'd0 || m_tuser !== exp_c.armed) begin
            $display("%t: mismatch, expected fr %0d rr %0d rl %0d fl %0d armed %b",
                     $realtime, exp_c.motor[0], exp_c.motor[1], exp_c.motor[2],
                     exp_c.motor[3], exp_c.armed);
            $display("%t:           actual fr %0d rr %0d rl %0d fl %0d armed %b",
                     $realtime, ow.motor_front_right, ow.motor_rear_right,
                     ow.motor_rear_left, ow.motor_front_left, m_tuser);
            err_count <= err_count + 1;
          end
        end
      end
    end
  end
endmodule

### verif/tb_cascaded_pid_quad_mixer.sv
module tb_cascaded_pid_quad_mixer;
  import cpqm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
  logic [135:0] s_tdata;
  logic [47:0]  m_tdata;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0]    cfg_data;
  int err_count, pending;
  int cycle_count;
  bit calm;
  bit hold_off;

  cascaded_pid_quad_mixer dut (.*);
  cpqm_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb_cascaded_pid_quad_mixer: errors");
      $finish;
    end
  end

  // Receiver: random stall bursts, a long hold-off on request, none at the end.
  initial begin
    int n;
    m_tready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(3) == 0) begin
        n = $urandom_range(1, 14);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic [135:0] make_word(int rr, int rp, int rt, int ry,
                                             int ar, int ap, int gr, int gp, int gy);
    in_word_t w;
    w = '0;
    w.rx_roll = RX_W'(rr); w.rx_pitch = RX_W'(rp);
    w.rx_throttle = RX_W'(rt); w.rx_yaw = RX_W'(ry);
    w.roll_angle = 14'(ar); w.pitch_angle = 14'(ap);
    w.roll_rate = 18'(gr); w.pitch_rate = 18'(gp); w.yaw_rate = 18'(gy);
    return w;
  endfunction

  // Valid stays high after an accepted word; gaps and drain() take it down.
  task automatic send_word(logic [135:0] d);
    int n;
    if (!calm && $urandom_range(2) == 0) begin
      n = $urandom_range(1, 14);
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    @(posedge clk iff s_tready);
  endtask

  task automatic write_gain(reg_idx_t idx, logic [GAIN_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk iff cfg_ready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk iff pending == 0);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [135:0] random_tick();
    int thr;
    if ($urandom_range(9) == 0)
      return {8'd0, 128'({$urandom, $urandom, $urandom, $urandom})};
    thr = ($urandom_range(19) == 0) ? $urandom_range(0, 999) : $urandom_range(1000, 2100);
    return make_word($urandom_range(900, 2100), $urandom_range(900, 2100), thr,
                     $urandom_range(900, 2100),
                     $signed($urandom_range(0, 10240)) - 5120,
                     $signed($urandom_range(0, 10240)) - 5120,
                     $signed($urandom_range(0, 20000)) - 10000,
                     $signed($urandom_range(0, 20000)) - 10000,
                     $signed($urandom_range(0, 20000)) - 10000);
  endfunction

  task automatic random_gains();
    for (int i = 0; i < 8; i++)
      write_gain(reg_idx_t'(i), ($urandom_range(3) == 0) ? 20'hFFFFF : 20'($urandom));
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ANGLE_KP;
    cfg_data = '0;
    calm = 1'b0;
    hold_off = 1'b0;
    cycle_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, disarm, throttle above range, out-of-range angles.
    send_word(make_word(1500, 1500, 1500, 1500, 0, 0, 0, 0, 0));
    send_word(make_word(4095, 4095, 4095, 4095, 8191, 8191, 131071, 131071, 131071));
    send_word(make_word(0, 0, 1000, 0, -8192, -8192, -131072, -131072, -131072));
    send_word(make_word(2000, 1000, 1800, 2000, 5120, -5120, 100, -100, 0));
    send_word(make_word(1000, 2000, 999, 1000, -5120, 5120, 0, 0, 0));
    send_word(make_word(1600, 1400, 1801, 1700, 256, -256, 5000, -5000, 2000));
    send_word(make_word(1500, 1500, 0, 1500, 0, 0, 0, 0, 0));
    for (int i = 0; i < 8; i++)
      send_word(make_word(2100, 900, 1900, 2100, -5120, 5120, -60000, 60000, -60000));
    send_word(make_word(4095, 0, 4095, 0, 0, 0, 0, 0, 0));
    send_word({8'd0, {128{1'b1}}});
    drain();

    // Long receiver hold-off while the sender keeps offering.
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) send_word(random_tick());
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: for (int i = 0; i < 8; i++) write_gain(reg_idx_t'(i), '0);
        1: for (int i = 0; i < 8; i++) write_gain(reg_idx_t'(i), 20'hFFFFF);
        5: begin
          write_gain(REG_ANGLE_KP, ANGLE_KP_RST); write_gain(REG_ANGLE_KI, ANGLE_KI_RST);
          write_gain(REG_ANGLE_KD, ANGLE_KD_RST); write_gain(REG_RATE_KP, RATE_KP_RST);
          write_gain(REG_RATE_KI, RATE_KI_RST);   write_gain(REG_RATE_KD, RATE_KD_RST);
          write_gain(REG_YAW_KP, YAW_KP_RST);     write_gain(REG_YAW_KI, YAW_KI_RST);
        end
        default: random_gains();
      endcase
      cfg_valid <= 1'b0;
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < 295; i++) send_word(random_tick());
      drain();
    end

    if (err_count == 0)
      $display("tb_cascaded_pid_quad_mixer: clean");
    else
      $display("tb_cascaded_pid_quad_mixer: errors");
    $finish;
  end
endmodule
